// ===== rtl/core/lmr_pkg.sv =====
package lmr_pkg;

    // default coordinate width and fixed colour width
    localparam int COORD_BITS_DEF = 12;
    localparam int COLOR_BITS     = 24;

    // request codes
    localparam logic REQ_START = 1'b0;
    localparam logic REQ_TICK  = 1'b1;

endpackage

// ===== rtl/core/lmr_req_if.sv =====
interface lmr_req_if #(
    parameter int COORD_BITS = lmr_pkg::COORD_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic                          req_type;
    logic [COORD_BITS-1:0]         start_x;
    logic [COORD_BITS-1:0]         start_y;
    logic [COORD_BITS-1:0]         end_x;
    logic [COORD_BITS-1:0]         end_y;
    logic [lmr_pkg::COLOR_BITS-1:0] line_color;

    modport source (
        output valid, req_type, start_x, start_y, end_x, end_y, line_color,
        input  ready
    );

    modport sink (
        input  valid, req_type, start_x, start_y, end_x, end_y, line_color,
        output ready
    );
endinterface

// ===== rtl/core/lmr_pix_if.sv =====
interface lmr_pix_if #(
    parameter int COORD_BITS = lmr_pkg::COORD_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic [COORD_BITS-1:0]         pixel_x;
    logic [COORD_BITS-1:0]         pixel_y;
    logic [lmr_pkg::COLOR_BITS-1:0] pixel_color;
    logic                          last_pixel;

    modport source (
        output valid, pixel_x, pixel_y, pixel_color, last_pixel,
        input  ready
    );

    modport sink (
        input  valid, pixel_x, pixel_y, pixel_color, last_pixel,
        output ready
    );
endinterface

// ===== rtl/core/line_midpoint_raster.sv =====
// a request's pixel is registered in the output entry, or the skid entry if held
// throughput: one request per cycle while skid is empty, a pixel per start/busy tick
// the rate is set by the decision update on the line state registers
// a two-entry output buffer keeps requests flowing while one pixel waits
// reset (rst_n low, asynchronous) clears the busy flag and both output valids
module line_midpoint_raster #(
    parameter int COORD_BITS = lmr_pkg::COORD_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    lmr_req_if.sink            req,
    lmr_pix_if.source          pix
);

    localparam int CW = COORD_BITS;
    localparam int DW = COORD_BITS + 3;
    localparam int KW = lmr_pkg::COLOR_BITS;

    // line state
    logic                 busy_reg, busy_next;
    logic [CW-1:0]        cur_x_reg, cur_x_next;
    logic [CW-1:0]        cur_y_reg, cur_y_next;
    logic [CW-1:0]        major_end_reg, major_end_next;
    logic                 steep_reg, steep_next;
    logic                 minor_up_reg, minor_up_next;
    logic signed [DW-1:0] decision_reg, decision_next;
    logic signed [DW-1:0] inc_move_reg, inc_move_next;
    logic signed [DW-1:0] inc_stay_reg, inc_stay_next;
    logic [KW-1:0]        color_reg, color_next;

    // output buffer
    logic                 out_valid_reg;
    logic [CW-1:0]        out_x_reg, out_y_reg;
    logic [KW-1:0]        out_color_reg;
    logic                 out_last_reg;
    logic                 skid_valid_reg;
    logic [CW-1:0]        skid_x_reg, skid_y_reg;
    logic [KW-1:0]        skid_color_reg;
    logic                 skid_last_reg;

    logic                 accept;
    logic                 pop;
    logic                 has_result;
    logic                 last_new;

    // start setup terms
    logic signed [CW:0]   dx, dy;
    logic [CW:0]          neg_dx, neg_dy;
    logic [CW-1:0]        adx, ady;
    logic signed [DW-1:0] adx_w, ady_w, adx2, ady2, diff_w;

    // tick terms
    logic                 move;
    logic [CW-1:0]        minor, major, minor_n, major_n;

    assign accept    = req.valid && req.ready;
    assign pop       = out_valid_reg && pix.ready;
    assign req.ready = !skid_valid_reg;

    // endpoint deltas and magnitudes
    always_comb
    begin
        dx     = $signed({1'b0, req.end_x}) - $signed({1'b0, req.start_x});
        dy     = $signed({1'b0, req.end_y}) - $signed({1'b0, req.start_y});
        neg_dx = -dx;
        neg_dy = -dy;
        adx    = dx[CW] ? neg_dx[CW-1:0] : dx[CW-1:0];
        ady    = dy[CW] ? neg_dy[CW-1:0] : dy[CW-1:0];
        adx_w  = $signed({3'b000, adx});
        ady_w  = $signed({3'b000, ady});
        adx2   = {adx_w[DW-2:0], 1'b0};
        ady2   = {ady_w[DW-2:0], 1'b0};
        diff_w = adx_w - ady_w;
    end

    // line setup on a start, one step of the line on a busy tick
    always_comb
    begin
        busy_next      = busy_reg;
        cur_x_next     = cur_x_reg;
        cur_y_next     = cur_y_reg;
        major_end_next = major_end_reg;
        steep_next     = steep_reg;
        minor_up_next  = minor_up_reg;
        decision_next  = decision_reg;
        inc_move_next  = inc_move_reg;
        inc_stay_next  = inc_stay_reg;
        color_next     = color_reg;
        has_result     = 1'b0;
        last_new       = 1'b0;

        move    = steep_reg ? !decision_reg[DW-1] : decision_reg[DW-1];
        minor   = steep_reg ? cur_x_reg : cur_y_reg;
        major   = steep_reg ? cur_y_reg : cur_x_reg;
        minor_n = minor_up_reg ? minor + 1'b1 : minor - 1'b1;
        major_n = major + 1'b1;

        if (accept)
        begin
            unique case (req.req_type)
                lmr_pkg::REQ_START:
                begin
                    has_result    = 1'b1;
                    color_next    = req.line_color;
                    minor_up_next = (dx[CW] && dy[CW])
                                 || (!dx[CW] && (dx != '0) && !dy[CW] && (dy != '0));
                    inc_move_next = {diff_w[DW-2:0], 1'b0};
                    if (ady <= adx)
                    begin
                        steep_next    = 1'b0;
                        decision_next = adx_w - ady2;
                        inc_stay_next = -ady2;
                        if (!dx[CW])
                        begin
                            cur_x_next     = req.start_x;
                            cur_y_next     = req.start_y;
                            major_end_next = req.end_x;
                        end
                        else
                        begin
                            cur_x_next     = req.end_x;
                            cur_y_next     = req.end_y;
                            major_end_next = req.start_x;
                        end
                    end
                    else
                    begin
                        steep_next    = 1'b1;
                        decision_next = adx2 - ady_w;
                        inc_stay_next = adx2;
                        if (!dy[CW])
                        begin
                            cur_x_next     = req.start_x;
                            cur_y_next     = req.start_y;
                            major_end_next = req.end_y;
                        end
                        else
                        begin
                            cur_x_next     = req.end_x;
                            cur_y_next     = req.end_y;
                            major_end_next = req.start_y;
                        end
                    end
                end
                lmr_pkg::REQ_TICK:
                begin
                    if (busy_reg)
                    begin
                        has_result    = 1'b1;
                        decision_next = decision_reg + (move ? inc_move_reg : inc_stay_reg);
                        if (steep_reg)
                        begin
                            cur_x_next = move ? minor_n : minor;
                            cur_y_next = major_n;
                        end
                        else
                        begin
                            cur_x_next = major_n;
                            cur_y_next = move ? minor_n : minor;
                        end
                    end
                end
                default: has_result = 1'b0;
            endcase
        end

        // emitted pixel decides whether the line continues
        if (has_result)
        begin
            last_new  = ((steep_next ? cur_y_next : cur_x_next) == major_end_next);
            busy_next = !last_new;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            if (skid_valid_reg)
            begin
                if (pop)
                begin
                    skid_valid_reg <= 1'b0;
                end
            end
            else if (has_result)
            begin
                if (out_valid_reg && !pop)
                begin
                    skid_valid_reg <= 1'b1;
                end
                else
                begin
                    out_valid_reg <= 1'b1;
                end
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // line state and pixel payload
    always_ff @(posedge clk)
    begin
        cur_x_reg     <= cur_x_next;
        cur_y_reg     <= cur_y_next;
        major_end_reg <= major_end_next;
        steep_reg     <= steep_next;
        minor_up_reg  <= minor_up_next;
        decision_reg  <= decision_next;
        inc_move_reg  <= inc_move_next;
        inc_stay_reg  <= inc_stay_next;
        color_reg     <= color_next;

        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_x_reg     <= skid_x_reg;
                out_y_reg     <= skid_y_reg;
                out_color_reg <= skid_color_reg;
                out_last_reg  <= skid_last_reg;
            end
        end
        else if (has_result)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_x_reg     <= cur_x_next;
                skid_y_reg     <= cur_y_next;
                skid_color_reg <= color_next;
                skid_last_reg  <= last_new;
            end
            else
            begin
                out_x_reg     <= cur_x_next;
                out_y_reg     <= cur_y_next;
                out_color_reg <= color_next;
                out_last_reg  <= last_new;
            end
        end
    end

    assign pix.valid       = out_valid_reg;
    assign pix.pixel_x     = out_x_reg;
    assign pix.pixel_y     = out_y_reg;
    assign pix.pixel_color = out_color_reg;
    assign pix.last_pixel  = out_last_reg;

    // skid entry only fills behind a held output
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid without output entry");

    // a start transaction always leaves a pixel buffered
    a_start_gives_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (req.req_type == lmr_pkg::REQ_START)) |=> out_valid_reg)
        else $error("start transaction produced no pixel");

    // the last pixel ends the line
    a_last_clears_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (has_result && last_new) |=> !busy_reg)
        else $error("line still busy after last pixel");

    // a busy line has not reached its end on the major axis
    a_busy_not_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> ((steep_reg ? cur_y_reg : cur_x_reg) != major_end_reg))
        else $error("busy while at major end");

endmodule
